[rtl/core/tdd_pkg.sv]
// Torus domain decomposition: shared types, constants and codes.
// Used by every module of the block but tdd_chk; depends on nothing.
package tdd_pkg;

    localparam int MAX_DOMAINS = 4096;
    localparam int CW = 13;
    localparam int QW = 12;
    localparam int LW = 24;
    localparam int PW = 2 * LW;
    localparam int AW = 64;
    localparam int IW = 3;

    localparam logic [IW-1:0] REG_COUNT = 3'd0;
    localparam logic [IW-1:0] REG_REQ_X = 3'd1;
    localparam logic [IW-1:0] REG_REQ_Y = 3'd2;
    localparam logic [IW-1:0] REG_REQ_Z = 3'd3;
    localparam logic [IW-1:0] REG_LEN_X = 3'd4;
    localparam logic [IW-1:0] REG_LEN_Y = 3'd5;
    localparam logic [IW-1:0] REG_LEN_Z = 3'd6;

    localparam logic [2:0] DIR_PX = 3'd0;
    localparam logic [2:0] DIR_MX = 3'd1;
    localparam logic [2:0] DIR_PY = 3'd2;
    localparam logic [2:0] DIR_MY = 3'd3;
    localparam logic [2:0] DIR_PZ = 3'd4;
    localparam logic [2:0] DIR_MZ = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_AXY, S_AXZ, S_AYZ, S_BASE, S_PINIT, S_XLOOP, S_XDIV,
        S_YLOOP, S_YDIV, S_A1, S_A2, S_A3, S_PEND, S_Q0, S_Q1, S_Q2, S_QDIV1,
        S_QDIV2, S_NB1, S_NB2, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH, OP_INIT, OP_SAVE_AXY, OP_SAVE_AXZ, OP_SAVE_AYZ,
        OP_SAVE_BASE, OP_PASS_INIT, OP_X_INC, OP_DIV_NX, OP_X_OK, OP_Y_INC,
        OP_DIV_MY, OP_Y_OK, OP_ACC1, OP_ACC2, OP_ACC3, OP_COMMIT, OP_FREE,
        OP_PLANE, OP_TOTAL, OP_DIV_P, OP_PZ, OP_PXY, OP_NB1, OP_NB2, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic grid_valid;
        logic x_gt_n;
        logic x_skip;
        logic y_gt_m;
        logic y_skip;
        logic div_busy;
        logic mul_busy;
        logic rem_zero;
        logic z_match;
        logic found;
        logic bad;
        logic out_free;
    } t_status;

endpackage

[rtl/core/tdd_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on tdd_pkg.
module tdd_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [tdd_pkg::CW-1:0] i_dividend,
    input  logic [tdd_pkg::CW-1:0] i_divisor,
    output logic                  o_busy,
    output logic [tdd_pkg::CW-1:0] o_quo,
    output logic [tdd_pkg::CW-1:0] o_rem
);
    import tdd_pkg::*;

    localparam int NW = $clog2(CW + 1);

    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_quo, r_rem, r_dvs;
    logic [CW:0]   w_sh, w_diff;
    logic          w_ge;

    always_comb begin
        w_sh   = {r_rem, r_quo[CW-1]};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_diff = w_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= NW'(CW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_sh[CW-1:0];
            r_quo <= {r_quo[CW-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

[rtl/core/tdd_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, stops early.
// Depends on tdd_pkg.
module tdd_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [tdd_pkg::PW-1:0] i_a,
    input  logic [tdd_pkg::LW-1:0] i_b,
    output logic                  o_busy,
    output logic [tdd_pkg::AW-1:0] o_prod
);
    import tdd_pkg::*;

    logic [AW-1:0] r_a, r_p;
    logic [LW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (i_start) begin
            r_b <= i_b;
        end else if (r_b != '0) begin
            r_b <= r_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= AW'(i_a);
            r_p <= '0;
        end else if (r_b != '0) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
        end
    end

    assign o_busy = r_b != '0;
    assign o_prod = r_p;
endmodule

[rtl/core/tdd_dpath.sv]
// Datapath: configuration registers, grid search and query registers.
// Depends on tdd_pkg, tdd_div and tdd_mul.
module tdd_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdd_pkg::t_cmd         i_cmd,
    output tdd_pkg::t_status      o_status,
    input  logic                  i_cfg_we,
    input  logic [tdd_pkg::IW-1:0] i_cfg_index,
    input  logic [tdd_pkg::LW-1:0] i_cfg_data,
    input  logic [tdd_pkg::QW-1:0] i_domain_number,
    input  logic [2:0]            i_direction,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [tdd_pkg::CW-1:0] o_grid_x,
    output logic [tdd_pkg::CW-1:0] o_grid_y,
    output logic [tdd_pkg::CW-1:0] o_grid_z,
    output logic                  o_fell_back,
    output logic [tdd_pkg::QW-1:0] o_pos_x,
    output logic [tdd_pkg::QW-1:0] o_pos_y,
    output logic [tdd_pkg::QW-1:0] o_pos_z,
    output logic [tdd_pkg::QW-1:0] o_neighbour_number,
    output logic                  o_at_boundary,
    output logic                  o_bad_query
);
    import tdd_pkg::*;

    localparam logic [CW-1:0] MAX_N = CW'(MAX_DOMAINS);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [CW-1:0] r_count, r_req_x, r_req_y, r_req_z;
    logic [LW-1:0] r_len_x, r_len_y, r_len_z;
    logic [CW-1:0] r_cgx, r_cgy, r_cgz;
    logic          r_cfb, r_valid;

    logic [PW-1:0] r_axy, r_axz, r_ayz;
    logic [AW-1:0] r_base, r_best, r_area;
    logic [CW-1:0] r_n, r_x, r_y, r_m, r_z, r_gx, r_gy, r_gz;
    logic          r_free, r_found;

    logic [QW-1:0] r_dom, r_px, r_py, r_pz, r_nx, r_ny;
    logic [2:0]    r_dir;
    logic [CW-1:0] r_plane;
    logic [2*CW-1:0] r_t;
    logic          r_bad, r_bnd;
    logic [QW-1:0] r_nbr;

    logic [CW-1:0] w_rx, w_ry, w_rz;
    logic          w_div_start, w_div_busy, w_mul_start, w_mul_busy;
    logic [CW-1:0] w_dividend, w_divisor, w_quo, w_rem;
    logic [PW-1:0] w_ma;
    logic [LW-1:0] w_mb;
    logic [AW-1:0] w_prod, w_cand;
    logic [2*CW-1:0] w_pl, w_tot;
    logic [QW-1:0] w_nx, w_ny, w_nz;
    logic          w_bnd;
    logic [CW:0]   w_px1, w_py1, w_pz1;

    assign w_rx = r_free ? '0 : r_req_x;
    assign w_ry = r_free ? '0 : r_req_y;
    assign w_rz = r_free ? '0 : r_req_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ONE;
            r_req_x <= '0;
            r_req_y <= '0;
            r_req_z <= '0;
            r_len_x <= LW'(256);
            r_len_y <= LW'(256);
            r_len_z <= LW'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COUNT: r_count <= i_cfg_data[CW-1:0];
                REG_REQ_X: r_req_x <= i_cfg_data[CW-1:0];
                REG_REQ_Y: r_req_y <= i_cfg_data[CW-1:0];
                REG_REQ_Z: r_req_z <= i_cfg_data[CW-1:0];
                REG_LEN_X: r_len_x <= i_cfg_data;
                REG_LEN_Y: r_len_y <= i_cfg_data;
                REG_LEN_Z: r_len_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cached grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cgx   <= '0;
            r_cgy   <= '0;
            r_cgz   <= '0;
            r_cfb   <= 1'b0;
        end else if (i_cfg_we && i_cfg_index <= REG_LEN_Z) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == OP_COMMIT) begin
            r_valid <= 1'b1;
            r_cgx   <= r_gx;
            r_cgy   <= r_gy;
            r_cgz   <= r_gz;
            r_cfb   <= r_free;
        end
    end

    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = r_n;
        w_divisor   = r_x;
        case (i_cmd.op)
            OP_DIV_NX: w_div_start = 1'b1;
            OP_DIV_MY: begin
                w_div_start = 1'b1;
                w_dividend  = r_m;
                w_divisor   = r_y;
            end
            OP_DIV_P: begin
                w_div_start = 1'b1;
                w_dividend  = CW'(r_dom);
                w_divisor   = r_plane;
            end
            OP_PZ: begin
                w_div_start = 1'b1;
                w_dividend  = w_rem;
                w_divisor   = r_cgx;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_mul_start = 1'b1;
        w_ma        = PW'(r_len_x);
        w_mb        = r_len_y;
        case (i_cmd.op)
            OP_INIT: ;
            OP_SAVE_AXY: w_mb = r_len_z;
            OP_SAVE_AXZ: begin
                w_ma = PW'(r_len_y);
                w_mb = r_len_z;
            end
            OP_SAVE_AYZ: begin
                w_ma = r_axy;
                w_mb = LW'(r_n);
            end
            OP_Y_OK: begin
                w_ma = r_axy;
                w_mb = LW'(w_quo);
            end
            OP_ACC1: begin
                w_ma = r_axz;
                w_mb = LW'(r_y);
            end
            OP_ACC2: begin
                w_ma = r_ayz;
                w_mb = LW'(r_x);
            end
            default: w_mul_start = 1'b0;
        endcase
    end

    tdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    tdd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_busy  (w_mul_busy),
        .o_prod  (w_prod)
    );

    assign w_cand = r_area + w_prod;

    // grid search
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_INIT: begin
                r_n    <= (r_count > MAX_N) ? MAX_N : r_count;
                r_free <= 1'b0;
            end
            OP_SAVE_AXY:  r_axy <= w_prod[PW-1:0];
            OP_SAVE_AXZ:  r_axz <= w_prod[PW-1:0];
            OP_SAVE_AYZ:  r_ayz <= w_prod[PW-1:0];
            OP_SAVE_BASE: r_base <= w_prod + AW'(r_axz) + AW'(r_ayz);
            OP_PASS_INIT: begin
                r_best  <= r_base;
                r_found <= (w_rx == '0) && (w_ry == '0) && (w_rz == '0);
                r_gx    <= ONE;
                r_gy    <= ONE;
                r_gz    <= r_n;
                r_x     <= ONE;
            end
            OP_X_INC: r_x <= r_x + 1'b1;
            OP_X_OK: begin
                r_m <= w_quo;
                r_y <= ONE;
            end
            OP_Y_INC: r_y <= r_y + 1'b1;
            OP_Y_OK:  r_z <= w_quo;
            OP_ACC1:  r_area <= w_prod;
            OP_ACC2:  r_area <= w_cand;
            OP_ACC3: begin
                if (w_cand < r_best || !r_found) begin
                    r_gx    <= r_x;
                    r_gy    <= r_y;
                    r_gz    <= r_z;
                    r_best  <= w_cand;
                    r_found <= 1'b1;
                end
                r_y <= r_y + 1'b1;
            end
            OP_FREE: r_free <= 1'b1;
            default: ;
        endcase
    end

    // query
    assign w_pl  = r_cgx * r_cgy;
    assign w_tot = r_plane * r_cgz;
    assign w_px1 = {2'b0, r_px} + 1'b1;
    assign w_py1 = {2'b0, r_py} + 1'b1;
    assign w_pz1 = {2'b0, r_pz} + 1'b1;

    always_comb begin
        w_nx  = r_px;
        w_ny  = r_py;
        w_nz  = r_pz;
        w_bnd = 1'b0;
        case (r_dir)
            DIR_PX: begin
                w_bnd = w_px1[CW-1:0] == r_cgx;
                w_nx  = w_bnd ? '0 : w_px1[QW-1:0];
            end
            DIR_MX: begin
                w_bnd = r_px == '0;
                w_nx  = w_bnd ? QW'(r_cgx - 1'b1) : r_px - 1'b1;
            end
            DIR_PY: begin
                w_bnd = w_py1[CW-1:0] == r_cgy;
                w_ny  = w_bnd ? '0 : w_py1[QW-1:0];
            end
            DIR_MY: begin
                w_bnd = r_py == '0;
                w_ny  = w_bnd ? QW'(r_cgy - 1'b1) : r_py - 1'b1;
            end
            DIR_PZ: begin
                w_bnd = w_pz1[CW-1:0] == r_cgz;
                w_nz  = w_bnd ? '0 : w_pz1[QW-1:0];
            end
            DIR_MZ: begin
                w_bnd = r_pz == '0;
                w_nz  = w_bnd ? QW'(r_cgz - 1'b1) : r_pz - 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_dom <= i_domain_number;
                r_dir <= i_direction;
            end
            OP_PLANE: r_plane <= w_pl[CW-1:0];
            OP_TOTAL: r_bad <= (r_dir > DIR_MZ) || ({14'b0, r_dom} >= w_tot);
            OP_PZ:    r_pz <= w_quo[QW-1:0];
            OP_PXY: begin
                r_py <= w_quo[QW-1:0];
                r_px <= w_rem[QW-1:0];
            end
            OP_NB1: begin
                r_nx  <= w_nx;
                r_ny  <= w_ny;
                r_bnd <= w_bnd;
                r_t   <= (2*CW)'(w_nz * r_plane);
            end
            OP_NB2: r_nbr <= QW'(r_t + (2*CW)'(r_ny * r_cgx) + (2*CW)'(r_nx));
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            o_grid_x           <= r_bad ? '0 : r_cgx;
            o_grid_y           <= r_bad ? '0 : r_cgy;
            o_grid_z           <= r_bad ? '0 : r_cgz;
            o_fell_back        <= r_bad ? 1'b0 : r_cfb;
            o_pos_x            <= r_bad ? '0 : r_px;
            o_pos_y            <= r_bad ? '0 : r_py;
            o_pos_z            <= r_bad ? '0 : r_pz;
            o_neighbour_number <= r_bad ? '0 : r_nbr;
            o_at_boundary      <= r_bad ? 1'b0 : r_bnd;
            o_bad_query        <= r_bad;
        end
    end

    always_comb begin
        o_status.grid_valid = r_valid;
        o_status.x_gt_n     = r_x > r_n;
        o_status.x_skip     = (w_rx != '0) && (r_x != w_rx);
        o_status.y_gt_m     = r_y > r_m;
        o_status.y_skip     = (w_ry != '0) && (r_y != w_ry);
        o_status.div_busy   = w_div_busy;
        o_status.mul_busy   = w_mul_busy;
        o_status.rem_zero   = w_rem == '0;
        o_status.z_match    = (w_rz == '0) || (w_quo == w_rz);
        o_status.found      = r_found;
        o_status.bad        = r_bad;
        o_status.out_free   = !o_out_valid || i_out_ready;
    end
endmodule

[rtl/core/tdd_ctrl.sv]
// Controller: sequences the grid search and the query through the datapath.
// Depends on tdd_pkg.
module tdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tdd_pkg::t_status i_status,
    output tdd_pkg::t_cmd    o_cmd
);
    import tdd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = i_status.grid_valid ? S_Q0 : S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_AXY;
            end
            S_AXY: if (!i_status.mul_busy) begin
                o_cmd.op = OP_SAVE_AXY;
                n_state  = S_AXZ;
            end
            S_AXZ: if (!i_status.mul_busy) begin
                o_cmd.op = OP_SAVE_AXZ;
                n_state  = S_AYZ;
            end
            S_AYZ: if (!i_status.mul_busy) begin
                o_cmd.op = OP_SAVE_AYZ;
                n_state  = S_BASE;
            end
            S_BASE: if (!i_status.mul_busy) begin
                o_cmd.op = OP_SAVE_BASE;
                n_state  = S_PINIT;
            end
            S_PINIT: begin
                o_cmd.op = OP_PASS_INIT;
                n_state  = S_XLOOP;
            end
            S_XLOOP: begin
                if (i_status.x_gt_n) begin
                    n_state = S_PEND;
                end else if (i_status.x_skip) begin
                    o_cmd.op = OP_X_INC;
                end else begin
                    o_cmd.op = OP_DIV_NX;
                    n_state  = S_XDIV;
                end
            end
            S_XDIV: if (!i_status.div_busy) begin
                if (i_status.rem_zero) begin
                    o_cmd.op = OP_X_OK;
                    n_state  = S_YLOOP;
                end else begin
                    o_cmd.op = OP_X_INC;
                    n_state  = S_XLOOP;
                end
            end
            S_YLOOP: begin
                if (i_status.y_gt_m) begin
                    o_cmd.op = OP_X_INC;
                    n_state  = S_XLOOP;
                end else if (i_status.y_skip) begin
                    o_cmd.op = OP_Y_INC;
                end else begin
                    o_cmd.op = OP_DIV_MY;
                    n_state  = S_YDIV;
                end
            end
            S_YDIV: if (!i_status.div_busy) begin
                if (i_status.rem_zero && i_status.z_match) begin
                    o_cmd.op = OP_Y_OK;
                    n_state  = S_A1;
                end else begin
                    o_cmd.op = OP_Y_INC;
                    n_state  = S_YLOOP;
                end
            end
            S_A1: if (!i_status.mul_busy) begin
                o_cmd.op = OP_ACC1;
                n_state  = S_A2;
            end
            S_A2: if (!i_status.mul_busy) begin
                o_cmd.op = OP_ACC2;
                n_state  = S_A3;
            end
            S_A3: if (!i_status.mul_busy) begin
                o_cmd.op = OP_ACC3;
                n_state  = S_YLOOP;
            end
            S_PEND: begin
                if (i_status.found) begin
                    o_cmd.op = OP_COMMIT;
                    n_state  = S_Q0;
                end else begin
                    o_cmd.op = OP_FREE;
                    n_state  = S_PINIT;
                end
            end
            S_Q0: begin
                o_cmd.op = OP_PLANE;
                n_state  = S_Q1;
            end
            S_Q1: begin
                o_cmd.op = OP_TOTAL;
                n_state  = S_Q2;
            end
            S_Q2: begin
                if (i_status.bad) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_DIV_P;
                    n_state  = S_QDIV1;
                end
            end
            S_QDIV1: if (!i_status.div_busy) begin
                o_cmd.op = OP_PZ;
                n_state  = S_QDIV2;
            end
            S_QDIV2: if (!i_status.div_busy) begin
                o_cmd.op = OP_PXY;
                n_state  = S_NB1;
            end
            S_NB1: begin
                o_cmd.op = OP_NB1;
                n_state  = S_NB2;
            end
            S_NB2: begin
                o_cmd.op = OP_NB2;
                n_state  = S_OUT;
            end
            S_OUT: if (i_status.out_free) begin
                o_cmd.op = OP_EMIT;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/core/torus_domain_decomposition.sv]
// Channel  | handshake                 | payload
// request  | i_in_valid / o_in_ready   | i_domain_number, i_direction
// result   | o_out_valid / i_out_ready | o_grid_*, o_fell_back, o_pos_*, o_neighbour_number,
//          |                           | o_at_boundary, o_bad_query
// config   | i_cfg_we                  | i_cfg_index, i_cfg_data
// A request with a cached grid waits on the serial divider twice; a bad request skips
// both divisions. The first request after reset or a write to a config register
// first runs the factor search, which waits on the serial divider for each candidate
// x and y that it tests, and on the shift-add multiplier for each matching factorisation.
// Reset is synchronous, active low; no clearing pass. A stalled result holds the output
// register; the next request is taken meanwhile but waits to emit.
module torus_domain_decomposition (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_domain_number,
    input  logic [2:0]  i_direction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [12:0] o_grid_x,
    output logic [12:0] o_grid_y,
    output logic [12:0] o_grid_z,
    output logic        o_fell_back,
    output logic [11:0] o_pos_x,
    output logic [11:0] o_pos_y,
    output logic [11:0] o_pos_z,
    output logic [11:0] o_neighbour_number,
    output logic        o_at_boundary,
    output logic        o_bad_query
);
    import tdd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    tdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tdd_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_domain_number    (i_domain_number),
        .i_direction        (i_direction),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_grid_x           (o_grid_x),
        .o_grid_y           (o_grid_y),
        .o_grid_z           (o_grid_z),
        .o_fell_back        (o_fell_back),
        .o_pos_x            (o_pos_x),
        .o_pos_y            (o_pos_y),
        .o_pos_z            (o_pos_z),
        .o_neighbour_number (o_neighbour_number),
        .o_at_boundary      (o_at_boundary),
        .o_bad_query        (o_bad_query)
    );
endmodule

[rtl/core/tdd_chk.sv]
// Port-level checks for torus_domain_decomposition, with its bind.
// Depends on the top level's ports only.
module tdd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [12:0] o_grid_x,
    input logic [11:0] o_pos_x,
    input logic [11:0] o_neighbour_number,
    input logic        o_bad_query
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_neighbour_number))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_query |-> o_grid_x == '0 && o_neighbour_number == '0)
        else $error("bad request with nonzero fields");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_query |-> {1'b0, o_pos_x} < o_grid_x)
        else $error("position beyond grid");
endmodule

bind torus_domain_decomposition tdd_chk u_tdd_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_grid_x           (o_grid_x),
    .o_pos_x            (o_pos_x),
    .o_neighbour_number (o_neighbour_number),
    .o_bad_query        (o_bad_query)
);
